// ----- sv/color_matrix_mix_clamp_shoulder_top_defines.svh -----
// assertion macros shared by the color matrix block
`ifndef COLOR_MATRIX_MIX_CLAMP_SHOULDER_TOP_DEFINES_SVH
`define COLOR_MATRIX_MIX_CLAMP_SHOULDER_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define CCM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define CCM_ASSERT_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ccm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ccm_pkg;

    // field and datapath widths
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = 48;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 34;
    localparam int RND_SH     = 12;
    localparam int V_W        = 20;
    localparam int VS_W       = 13;
    localparam int DEN_W      = 26;
    localparam int D2_W       = DEN_W + 1;
    localparam int DIV_W      = 35;
    localparam int Q_W        = 8;
    localparam int CFG_IDX_W  = 2;

    // pipeline shape: two bits of quotient per divider stage
    localparam int DIV_STAGES = 4;
    localparam int MIX_STAGES = 2;
    localparam int SH_STAGES  = DIV_STAGES + 3;
    localparam int PIPE_DEPTH = MIX_STAGES + SH_STAGES;

    // identity matrix rows (reset values)
    localparam logic [ROW_W-1:0] ID_RED   = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ID_GREEN = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ID_BLUE  = 48'h1000_0000_0000;

    // shoulder constants in Q2.13; RND_HALF is the rounding half of the 12-bit product shift
    localparam logic [V_W-1:0]   KNEE     = 20'd7782;
    localparam logic [SUM_W-1:0] RND_HALF = 34'd2048;
    localparam logic [DEN_W-1:0] DEN_BASE = 26'd8192;
    localparam logic [PIX_W-1:0] OUT_MAX  = 16'd7988;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_ROW   = 2'd0,
        CFG_GREEN_ROW = 2'd1,
        CFG_BLUE_ROW  = 2'd2
    } cfg_idx_e;

    typedef struct packed {
        logic signed [PIX_W-1:0] red_in;
        logic signed [PIX_W-1:0] green_in;
        logic signed [PIX_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] red_out;
        logic signed [PIX_W-1:0] green_out;
        logic signed [PIX_W-1:0] blue_out;
    } pix_out_t;

    // mixer result handed to the shoulder units
    typedef struct packed {
        logic                        ident;
        logic [2:0][PIX_W-1:0]       raw;
        logic [2:0][SUM_W-1:0]       sum;
    } mix_t;

    // per-channel side data riding along the shoulder pipeline
    typedef struct packed {
        logic             ident;
        logic [PIX_W-1:0] raw;
        logic             pos;
        logic             big;
        logic [VS_W-1:0]  vsmall;
    } side_t;

    typedef struct packed {
        logic             ident;
        logic [PIX_W-1:0] value;
    } ch_out_t;

endpackage

`default_nettype wire

// ----- sv/ccm_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ccm_mix import ccm_pkg::*; (
    input  logic                  aclk,
    input  logic [MIX_STAGES-1:0] en,
    input  pix_in_t               in_data,
    input  logic [ROW_W-1:0]      red_row,
    input  logic [ROW_W-1:0]      green_row,
    input  logic [ROW_W-1:0]      blue_row,
    input  logic                  ident,
    output mix_t                  mix_out
);

    logic [2:0][ROW_W-1:0] rows;
    logic [2:0][PIX_W-1:0] pix;

    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic                     ident_reg;
    logic [2:0][PIX_W-1:0]    raw_reg;
    mix_t                     mix_reg;
    mix_t                     mix_next;

    assign rows = {blue_row, green_row, red_row};
    assign pix  = {in_data.blue_in, in_data.green_in, in_data.red_in};

    // nine coefficient by channel products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(rows[i][j*COEF_W +: COEF_W]) * $signed(pix[j]);
            end
        end
    end

    // sum of three products per output channel
    always_comb begin
        mix_next.ident = ident_reg;
        mix_next.raw   = raw_reg;
        for (int i = 0; i < 3; i++) begin
            mix_next.sum[i] = {{(SUM_W-PROD_W){prod_reg[i][0][PROD_W-1]}}, prod_reg[i][0]}
                            + {{(SUM_W-PROD_W){prod_reg[i][1][PROD_W-1]}}, prod_reg[i][1]}
                            + {{(SUM_W-PROD_W){prod_reg[i][2][PROD_W-1]}}, prod_reg[i][2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg  <= prod_next;
            ident_reg <= ident;
            raw_reg   <= pix;
        end
        if (en[1]) begin
            mix_reg <= mix_next;
        end
    end

    assign mix_out = mix_reg;

endmodule

`default_nettype wire

// ----- sv/ccm_shoulder.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ccm_shoulder import ccm_pkg::*; (
    input  logic                 aclk,
    input  logic [SH_STAGES-1:0] en,
    input  logic [SUM_W-1:0]     sum,
    input  logic [PIX_W-1:0]     raw,
    input  logic                 ident,
    output ch_out_t              ch_out
);

    // round, floor and knee test
    side_t          side_a_reg;
    side_t          side_a_next;
    logic [V_W-1:0] u_reg;
    logic [V_W-1:0] u_next;

    always_comb begin
        logic [SUM_W-1:0] t;
        logic [V_W-1:0]   v;
        t                  = sum + RND_HALF;
        v                  = t[V_W+RND_SH-1:RND_SH];
        side_a_next.ident  = ident;
        side_a_next.raw    = raw;
        side_a_next.pos    = !sum[SUM_W-1] && (sum != '0);
        side_a_next.big    = side_a_next.pos && (v > KNEE);
        side_a_next.vsmall = v[VS_W-1:0];
        u_next             = side_a_next.big ? (v - KNEE) : '0;
    end

    // numerator and doubled denominator of the rounded quotient
    logic [DIV_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [D2_W-1:0]  d2_reg   [DIV_STAGES+1];
    logic [Q_W-1:0]   q_reg    [DIV_STAGES+1];
    side_t            side_reg [DIV_STAGES+1];

    logic [DEN_W-1:0] den_b;
    logic [DIV_W-1:0] num_b;

    assign den_b = DEN_BASE + DEN_W'({u_reg, 5'b0}) + DEN_W'({u_reg, 3'b0});
    assign num_b = DIV_W'({u_reg, 14'b0}) + DIV_W'(den_b);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_a_reg <= side_a_next;
            u_reg      <= u_next;
        end
        if (en[1]) begin
            rem_reg[0]  <= num_b;
            d2_reg[0]   <= {den_b, 1'b0};
            q_reg[0]    <= '0;
            side_reg[0] <= side_a_reg;
        end
    end

    // restoring divider, two quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int B_HI = Q_W - 1 - 2*k;
        localparam int B_LO = B_HI - 1;

        logic [DIV_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        always_comb begin
            logic [DIV_W-1:0] trial_hi;
            logic [DIV_W-1:0] trial_lo;
            trial_hi = DIV_W'(d2_reg[k]) << B_HI;
            trial_lo = DIV_W'(d2_reg[k]) << B_LO;
            rem_next = rem_reg[k];
            q_next   = q_reg[k];
            if (rem_next >= trial_hi) begin
                rem_next     = rem_next - trial_hi;
                q_next[B_HI] = 1'b1;
            end
            if (rem_next >= trial_lo) begin
                rem_next     = rem_next - trial_lo;
                q_next[B_LO] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[2+k]) begin
                rem_reg[k+1]  <= rem_next;
                d2_reg[k+1]   <= d2_reg[k];
                q_reg[k+1]    <= q_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // final select: passthrough, floor, linear or shoulder
    ch_out_t out_reg;
    ch_out_t out_next;

    always_comb begin
        side_t s;
        s              = side_reg[DIV_STAGES];
        out_next.ident = s.ident;
        if (s.ident) begin
            out_next.value = s.raw;
        end else if (!s.pos) begin
            out_next.value = '0;
        end else if (!s.big) begin
            out_next.value = PIX_W'(s.vsmall);
        end else begin
            out_next.value = PIX_W'(KNEE) + PIX_W'(q_reg[DIV_STAGES]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[SH_STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    assign ch_out = out_reg;

endmodule

`default_nettype wire

// ----- sv/color_matrix_mix_clamp_shoulder_top.sv -----
// the accepting edge loads the item into the first of nine register stages;
// throughput: one item per cycle when m_ready does not stall, through nine
//   register stages (products, sums, rounding, shoulder setup, four 2-bit
//   divider stages, output select)
// reset: aresetn low clears all stage valid bits and loads the identity matrix,
//   under which pixels pass through unchanged
`timescale 1ns / 1ps
`default_nettype none
`include "color_matrix_mix_clamp_shoulder_top_defines.svh"

module color_matrix_mix_clamp_shoulder_top import ccm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pix_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pix_out_t             m_data
);

    // matrix row registers
    logic [ROW_W-1:0] red_row_reg;
    logic [ROW_W-1:0] green_row_reg;
    logic [ROW_W-1:0] blue_row_reg;
    logic             ident;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_row_reg   <= ID_RED;
            green_row_reg <= ID_GREEN;
            blue_row_reg  <= ID_BLUE;
        end else if (cfg_we) begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_RED_ROW:   red_row_reg   <= cfg_wdata;
                CFG_GREEN_ROW: green_row_reg <= cfg_wdata;
                CFG_BLUE_ROW:  blue_row_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ident = (red_row_reg == ID_RED) && (green_row_reg == ID_GREEN)
                && (blue_row_reg == ID_BLUE);

    // stage valid bits and per-stage advance, bubbles collapse
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] en;

    always_comb begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[PIPE_DEPTH-1];

    // matrix multiply and sum
    mix_t mix;

    ccm_mix u_mix (
        .aclk      (aclk),
        .en        (en[MIX_STAGES-1:0]),
        .in_data   (s_data),
        .red_row   (red_row_reg),
        .green_row (green_row_reg),
        .blue_row  (blue_row_reg),
        .ident     (ident),
        .mix_out   (mix)
    );

    // per-channel clamp and shoulder
    ch_out_t ch [3];

    for (genvar i = 0; i < 3; i++) begin : g_ch
        ccm_shoulder u_shoulder (
            .aclk   (aclk),
            .en     (en[PIPE_DEPTH-1:MIX_STAGES]),
            .sum    (mix.sum[i]),
            .raw    (mix.raw[i]),
            .ident  (mix.ident),
            .ch_out (ch[i])
        );
    end

    assign m_data.red_out   = ch[0].value;
    assign m_data.green_out = ch[1].value;
    assign m_data.blue_out  = ch[2].value;

    // mixed results outside passthrough stay in the floor-to-shoulder range
    logic [2:0] ch_in_range;

    for (genvar i = 0; i < 3; i++) begin : g_rng
        assign ch_in_range[i] = ch[i].ident
                             || (!ch[i].value[PIX_W-1] && (ch[i].value < OUT_MAX));
    end

    `CCM_ASSERT_IMP(a_red_range, aclk, aresetn, m_valid, ch_in_range[0], "red out of range")
    `CCM_ASSERT_IMP(a_green_range, aclk, aresetn, m_valid, ch_in_range[1], "green out of range")
    `CCM_ASSERT_IMP(a_blue_range, aclk, aresetn, m_valid, ch_in_range[2], "blue out of range")
    // reset empties the pipeline
    `CCM_ASSERT_NXT(a_reset_flush, aclk, !aresetn, !m_valid && (valid_reg == '0), "not flushed")

endmodule

`default_nettype wire
